// ===== src/vgs_pkg.sv =====
// ----------------------------------------------------------------------------
// vgs_pkg
// Shared constants, codes, types and small helper functions for the
// visibility grid search block.
// ----------------------------------------------------------------------------
package vgs_pkg;

    localparam int GRID_SIDE  = 64;
    localparam int FRAC_BITS  = 8;
    localparam int ROW_W      = $clog2(GRID_SIDE);
    localparam int BND_W      = ROW_W + 1;
    localparam int CW         = 16;
    localparam int DW         = ((ROW_W + FRAC_BITS > CW) ? ROW_W + FRAC_BITS : CW) + 2;
    localparam int SQ_W       = 2 * DW;
    localparam int SUM_W      = SQ_W + 1;
    localparam int WALK_W     = ROW_W + 3;
    localparam int STEP_W     = ROW_W + 2;
    localparam int STEP_LIMIT = 2 * GRID_SIDE + 1;
    localparam int TILE_SIDE  = 1 << FRAC_BITS;
    localparam int HALF_TILE  = TILE_SIDE / 2;
    localparam int SPAN       = GRID_SIDE * TILE_SIDE;
    localparam int ROOT_MAX   = 11;
    localparam int ROOT_W     = 4;
    localparam int K_W        = 6;
    localparam int N_W        = 7;

    // side of one area square for each root, in tiles
    localparam int AREA_SIDE [ROOT_MAX+1] = '{
        0,
        GRID_SIDE / 1, GRID_SIDE / 2, GRID_SIDE / 3, GRID_SIDE / 4,
        GRID_SIDE / 5, GRID_SIDE / 6, GRID_SIDE / 7, GRID_SIDE / 8,
        GRID_SIDE / 9, GRID_SIDE / 10, GRID_SIDE / 11
    };

    localparam logic [2:0] CMD_WRITE   = 3'd0;
    localparam logic [2:0] CMD_CLEAR   = 3'd1;
    localparam logic [2:0] CMD_FIRST   = 3'd2;
    localparam logic [2:0] CMD_NEAREST = 3'd3;
    localparam logic [2:0] CMD_SPIRAL  = 3'd4;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NONE    = 2'd1;
    localparam logic [1:0] STAT_OUTSIDE = 2'd2;

    typedef struct packed {
        logic             ok;
        logic [BND_W-1:0] r0;
        logic [BND_W-1:0] r1;
        logic [BND_W-1:0] c0;
        logic [BND_W-1:0] c1;
    } area_res_t;

    // floor square root of the area count
    function automatic logic [ROOT_W-1:0] area_root(input logic [N_W-1:0] n);
        logic [ROOT_W-1:0] a;
        a = '0;
        for (int i = 1; i <= ROOT_MAX; i++) begin
            if (i * i <= int'(n)) begin
                a = ROOT_W'(i);
            end
        end
        return a;
    endfunction

    // side of one area square in tiles
    function automatic logic [BND_W-1:0] area_side(input logic [ROOT_W-1:0] a);
        logic [BND_W-1:0] s;
        s = '0;
        for (int i = 1; i <= ROOT_MAX; i++) begin
            if (int'(a) == i) begin
                s = BND_W'(AREA_SIDE[i]);
            end
        end
        return s;
    endfunction

endpackage

// ===== src/visibility_grid_search.sv =====
// ----------------------------------------------------------------------------
// visibility_grid_search
// Grid of visibility bits held in a row memory with tile write, clear and
// first-match, nearest-match and spiral searches.
// ----------------------------------------------------------------------------
// One command word in, one result word out. The grid lives in a 64-word by
// 64-bit row memory with one read port, and that port sets the pace: a tile
// write reads its row word and then writes it back, and a clear only drops
// the per-row valid bits at once. First and nearest match wait for the area
// unit. First match then reads and checks one row word at a time, a read
// state and then a check state per area row. Nearest match checks one tile
// per cycle, after a row read and a latch state per area row. The spiral
// search walks one tile per cycle and ends at the first visible tile, or at
// its step limit when nothing is visible. A new command is taken once the
// previous one finishes and the output register is free for its result.
// ----------------------------------------------------------------------------
module visibility_grid_search (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tile_row, tile_col, bit_value, area_number, number_of_areas, ref_x, ref_z
    input  logic [63:0] s_tdata,
    // cmd
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // found_row, found_col
    output logic [15:0] m_tdata,
    // status
    output logic [1:0]  m_tuser
);
    import vgs_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_AREA = 4'd1;
    localparam logic [3:0] S_WMOD = 4'd2;
    localparam logic [3:0] S_FRD  = 4'd3;
    localparam logic [3:0] S_FCHK = 4'd4;
    localparam logic [3:0] S_NROW = 4'd5;
    localparam logic [3:0] S_NLAT = 4'd6;
    localparam logic [3:0] S_NCOL = 4'd7;
    localparam logic [3:0] S_WALK = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    // input word fields
    logic [2:0]           in_cmd;
    logic [5:0]           in_row, in_col;
    logic                 in_bit;
    logic [5:0]           in_k;
    logic [6:0]           in_n;
    logic signed [CW-1:0] in_x, in_z;

    assign in_cmd = s_tuser;
    assign in_row = s_tdata[5:0];
    assign in_col = s_tdata[11:6];
    assign in_bit = s_tdata[12];
    assign in_k   = s_tdata[18:13];
    assign in_n   = s_tdata[25:19];
    assign in_x   = s_tdata[41:26];
    assign in_z   = s_tdata[57:42];

    logic [3:0]           state_reg, state_next;
    logic                 want_reg;
    logic                 is_near_reg;
    logic signed [CW-1:0] x_reg, z_reg;
    logic [GRID_SIDE-1:0] row_valid_reg;
    logic                 rd_vld_reg;
    logic [BND_W-1:0]     row_reg, col_reg;
    area_res_t            bnd_reg;
    logic [GRID_SIDE-1:0] word_reg;
    logic [SQ_W-1:0]      dz2_reg;
    logic                 p_valid_reg;
    logic [SQ_W-1:0]      p_dx2_reg;
    logic [ROW_W-1:0]     p_col_reg;
    logic [SUM_W-1:0]     best_reg;
    logic [1:0]           res_status_reg;
    logic [ROW_W-1:0]     res_row_reg, res_col_reg;
    logic                 m_valid_reg;
    logic [1:0]           m_status_reg;
    logic [ROW_W-1:0]     m_row_reg, m_col_reg;

    // spiral walk
    logic [STEP_W-1:0]        step_reg, left_reg;
    logic [1:0]               dir_reg;
    logic signed [1:0]        sig_reg;
    logic signed [WALK_W-1:0] wrow_reg, wcol_reg;
    logic                     pend_reg;
    logic [ROW_W-1:0]         pend_col_reg;

    // memory and area unit
    logic                 ram_we, ram_re;
    logic [ROW_W-1:0]     ram_waddr, ram_raddr;
    logic [GRID_SIDE-1:0] ram_wdata, ram_rdata, rd_word;
    logic                 area_start, area_done;
    area_res_t            area_res;

    vgs_ram #(.WIDTH(GRID_SIDE), .DEPTH(GRID_SIDE)) u_rows (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    vgs_area u_area (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (area_start),
        .k       (in_k),
        .n       (in_n),
        .done    (area_done),
        .res     (area_res)
    );

    // rows never written since the last clear read as hidden
    assign rd_word = rd_vld_reg ? ram_rdata : '0;

    logic accept;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // first-match row check
    logic [GRID_SIDE-1:0] fm_sel;
    logic [ROW_W-1:0]     fm_idx;
    logic                 fm_hit;
    always_comb begin
        for (int i = 0; i < GRID_SIDE; i++) begin
            fm_sel[i] = ((want_reg ? rd_word[i] : ~rd_word[i]) &&
                         (BND_W'(i) >= bnd_reg.c0) && (BND_W'(i) < bnd_reg.c1));
        end
        fm_idx = '0;
        for (int i = GRID_SIDE - 1; i >= 0; i--) begin
            if (fm_sel[i]) begin
                fm_idx = ROW_W'(i);
            end
        end
        fm_hit = |fm_sel;
    end

    // distance terms
    logic signed [DW-1:0]   dx_c, dz_c;
    logic signed [SQ_W-1:0] dx2_c, dz2_c;
    logic [SUM_W-1:0]       dist_c;
    assign dx_c   = DW'({col_reg[ROW_W-1:0], {FRAC_BITS{1'b0}}}) + DW'(HALF_TILE) - DW'(x_reg);
    assign dz_c   = DW'({row_reg[ROW_W-1:0], {FRAC_BITS{1'b0}}}) + DW'(HALF_TILE) - DW'(z_reg);
    assign dx2_c  = dx_c * dx_c;
    assign dz2_c  = dz_c * dz_c;
    assign dist_c = SUM_W'(p_dx2_reg) + SUM_W'(dz2_reg);

    // spiral: start tile and the next move
    logic                     sp_inside;
    logic [CW-1:0]            xm1, zm1;
    logic                     turn;
    logic [1:0]               dir_n;
    logic signed [1:0]        sig_n;
    logic [STEP_W-1:0]        left_t, step_n;
    logic signed [WALK_W-1:0] wrow_n, wcol_n;
    logic                     in_grid, walking, walk_hit;

    assign sp_inside = (in_x > 0) && (in_z > 0) &&
                       (DW'(in_x) <= DW'(SPAN)) && (DW'(in_z) <= DW'(SPAN));
    assign xm1 = in_x - CW'(1);
    assign zm1 = in_z - CW'(1);

    always_comb begin
        turn   = (left_reg == '0);
        dir_n  = turn ? dir_reg + 2'd1 : dir_reg;
        sig_n  = turn ? ((dir_n == 2'd0 || dir_n == 2'd1) ? 2'sd1 : -2'sd1) : sig_reg;
        left_t = turn ? step_reg : left_reg;
        step_n = (turn && dir_n[0]) ? step_reg + STEP_W'(1) : step_reg;
        wrow_n = dir_n[0] ? wrow_reg + WALK_W'(sig_n) : wrow_reg;
        wcol_n = dir_n[0] ? wcol_reg : wcol_reg + WALK_W'(sig_n);
        in_grid = (wrow_n >= 0) && (wrow_n < WALK_W'(GRID_SIDE)) &&
                  (wcol_n >= 0) && (wcol_n < WALK_W'(GRID_SIDE));
    end
    assign walking  = (step_reg < STEP_W'(STEP_LIMIT));
    assign walk_hit = pend_reg && rd_word[pend_col_reg];

    // memory port control
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = row_reg[ROW_W-1:0];
        ram_we    = 1'b0;
        ram_waddr = row_reg[ROW_W-1:0];
        for (int i = 0; i < GRID_SIDE; i++) begin
            ram_wdata[i] = (ROW_W'(i) == col_reg[ROW_W-1:0]) ? want_reg : rd_word[i];
        end
        area_start = 1'b0;
        if (accept) begin
            if (in_cmd == CMD_WRITE) begin
                ram_re    = 1'b1;
                ram_raddr = ROW_W'(in_row);
            end
            area_start = (in_cmd == CMD_FIRST) || (in_cmd == CMD_NEAREST);
        end
        unique case (state_reg)
            S_WMOD: ram_we = 1'b1;
            S_FRD, S_NROW: ram_re = 1'b1;
            S_WALK: begin
                ram_re    = !walk_hit && walking && in_grid;
                ram_raddr = wrow_n[ROW_W-1:0];
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (in_cmd)
                        CMD_WRITE: begin
                            if (BND_W'(in_row) < BND_W'(GRID_SIDE) &&
                                BND_W'(in_col) < BND_W'(GRID_SIDE)) begin
                                state_next = S_WMOD;
                            end else begin
                                state_next = S_DONE;
                            end
                        end
                        CMD_FIRST, CMD_NEAREST: state_next = S_AREA;
                        CMD_SPIRAL: state_next = sp_inside ? S_WALK : S_DONE;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_AREA: begin
                if (area_done) begin
                    if (!area_res.ok) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = is_near_reg ? S_NROW : S_FRD;
                    end
                end
            end
            S_WMOD: state_next = S_DONE;
            S_FRD:  state_next = S_FCHK;
            S_FCHK: begin
                if (fm_hit || row_reg + BND_W'(1) >= bnd_reg.r1) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_FRD;
                end
            end
            S_NROW: state_next = S_NLAT;
            S_NLAT: state_next = S_NCOL;
            S_NCOL: begin
                if (col_reg >= bnd_reg.c1) begin
                    state_next = (row_reg + BND_W'(1) >= bnd_reg.r1) ? S_DONE : S_NROW;
                end
            end
            S_WALK: begin
                if (walk_hit || (!walking && !pend_reg)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            pend_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept && in_cmd == CMD_CLEAR) begin
                row_valid_reg <= '0;
            end else if (ram_we) begin
                row_valid_reg[ram_waddr] <= 1'b1;
            end
            if (state_reg == S_DONE && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            p_valid_reg <= (state_reg == S_NCOL) && (col_reg < bnd_reg.c1) &&
                           (word_reg[col_reg[ROW_W-1:0]] == want_reg);
            if (state_reg == S_WALK) begin
                pend_reg <= !walk_hit && walking && in_grid;
            end else begin
                pend_reg <= 1'b0;
            end
        end

        if (ram_re) begin
            rd_vld_reg <= row_valid_reg[ram_raddr];
        end

        if (accept) begin
            want_reg       <= in_bit;
            is_near_reg    <= (in_cmd == CMD_NEAREST);
            x_reg          <= in_x;
            z_reg          <= in_z;
            row_reg        <= BND_W'(in_row);
            col_reg        <= BND_W'(in_col);
            res_row_reg    <= '0;
            res_col_reg    <= '0;
            if ((in_cmd == CMD_WRITE && BND_W'(in_row) < BND_W'(GRID_SIDE) &&
                 BND_W'(in_col) < BND_W'(GRID_SIDE)) || in_cmd == CMD_CLEAR) begin
                res_status_reg <= STAT_OK;
            end else if (in_cmd == CMD_SPIRAL && !sp_inside) begin
                res_status_reg <= STAT_OUTSIDE;
            end else begin
                res_status_reg <= STAT_NONE;
            end
            // null first move rechecks the start tile
            step_reg <= STEP_W'(1);
            left_reg <= STEP_W'(1);
            dir_reg  <= 2'd3;
            sig_reg  <= 2'sd0;
            wrow_reg <= WALK_W'(zm1[FRAC_BITS +: ROW_W]);
            wcol_reg <= WALK_W'(xm1[FRAC_BITS +: ROW_W]);
        end

        if (state_reg == S_AREA && area_done) begin
            bnd_reg <= area_res;
            row_reg <= area_res.r0;
        end

        if (state_reg == S_FCHK) begin
            if (fm_hit) begin
                res_status_reg <= STAT_OK;
                res_row_reg    <= row_reg[ROW_W-1:0];
                res_col_reg    <= fm_idx;
            end
            row_reg <= row_reg + BND_W'(1);
        end

        if (state_reg == S_NROW) begin
            dz2_reg <= SQ_W'(dz2_c);
            col_reg <= bnd_reg.c0;
        end
        if (state_reg == S_NLAT) begin
            word_reg <= rd_word;
        end
        if (state_reg == S_NCOL) begin
            if (col_reg < bnd_reg.c1) begin
                p_dx2_reg <= SQ_W'(dx2_c);
                p_col_reg <= col_reg[ROW_W-1:0];
                col_reg   <= col_reg + BND_W'(1);
            end else begin
                row_reg <= row_reg + BND_W'(1);
            end
        end
        // strict less keeps the earliest tile on ties
        if (p_valid_reg && (res_status_reg != STAT_OK || dist_c < best_reg)) begin
            best_reg       <= dist_c;
            res_status_reg <= STAT_OK;
            res_row_reg    <= row_reg[ROW_W-1:0];
            res_col_reg    <= p_col_reg;
        end

        if (state_reg == S_WALK) begin
            if (walk_hit) begin
                res_status_reg <= STAT_OK;
                res_row_reg    <= row_reg[ROW_W-1:0];
                res_col_reg    <= pend_col_reg;
            end else if (walking) begin
                step_reg     <= step_n;
                left_reg     <= left_t - STEP_W'(1);
                dir_reg      <= dir_n;
                sig_reg      <= sig_n;
                wrow_reg     <= wrow_n;
                wcol_reg     <= wcol_n;
                row_reg      <= BND_W'(wrow_n[ROW_W-1:0]);
                pend_col_reg <= wcol_n[ROW_W-1:0];
            end
        end

        if (state_reg == S_DONE && (!m_valid_reg || m_tready)) begin
            m_status_reg <= res_status_reg;
            m_row_reg    <= res_row_reg;
            m_col_reg    <= res_col_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = 16'({m_col_reg, m_row_reg});

endmodule

// ===== src/vgs_ram.sv =====
// ----------------------------------------------------------------------------
// vgs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/vgs_area.sv =====
// ----------------------------------------------------------------------------
// vgs_area
// Area bounds unit: turns an area index and area count into half-open row
// and column ranges, dividing the index by the root one subtract a cycle.
// ----------------------------------------------------------------------------
module vgs_area (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [5:0]           k,
    input  logic [6:0]           n,
    output logic                 done,
    output vgs_pkg::area_res_t   res
);
    import vgs_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    area_res_t         res_reg, res_next;
    logic [ROOT_W-1:0] a_reg, a_next;
    logic [BND_W-1:0]  side_reg, side_next;
    logic [K_W-1:0]    rem_reg, rem_next;
    logic [K_W-1:0]    q_reg, q_next;
    logic [ROOT_W-1:0] root_c;
    logic [BND_W-1:0]  side_c;
    logic [K_W+BND_W-1:0] r0_prod, c0_prod;

    assign root_c  = area_root(n);
    assign side_c  = area_side(root_c);
    assign r0_prod = q_reg * side_reg;
    assign c0_prod = rem_reg * side_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        a_next    = a_reg;
        side_next = side_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start) begin
            res_next = '0;
            if (n == '0) begin
                done_next = 1'b1;
            end else if (n == N_W'(1)) begin
                res_next.ok = 1'b1;
                res_next.r1 = BND_W'(GRID_SIDE);
                res_next.c1 = BND_W'(GRID_SIDE);
                done_next   = 1'b1;
            end else if (side_c == '0) begin
                done_next = 1'b1;
            end else begin
                a_next    = root_c;
                side_next = side_c;
                rem_next  = k;
                q_next    = '0;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (rem_reg >= K_W'(a_reg)) begin
                rem_next = rem_reg - K_W'(a_reg);
                q_next   = q_reg + K_W'(1);
            end else begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (q_reg < K_W'(a_reg)) begin
                    res_next.ok = 1'b1;
                    res_next.r0 = BND_W'(r0_prod);
                    res_next.c0 = BND_W'(c0_prod);
                    res_next.r1 = BND_W'(r0_prod) + side_reg;
                    res_next.c1 = BND_W'(c0_prod) + side_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        res_reg  <= res_next;
        a_reg    <= a_next;
        side_reg <= side_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule
